// ===== rtl/nkpt_pkg.sv =====
package nkpt_pkg;

    // list depth and derived index widths
    localparam int MAX_ROWS = 16;
    localparam int AW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW       = $clog2(MAX_ROWS + 1);

    localparam int DIST_W = 33;
    localparam int PAY_W  = 44;
    localparam int ROW_W  = DIST_W + PAY_W;

    localparam int IN_W  = 120;
    localparam int OUT_W = 128;

    // commands
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_VIEW  = 2'd1;
    localparam logic [1:0] CMD_OFFER = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_PROBE_X = 2'd1;
    localparam logic [1:0] REG_PROBE_Y = 2'd2;
    localparam logic [1:0] REG_RADIUS  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_FULL,
        ST_CMP,
        ST_WRITE,
        ST_RDATA,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [DIST_W-1:0] dist_sq;
        logic [PAY_W-1:0]  payload;
    } t_row;

endpackage

// ===== rtl/nearest_k_point_tracker.sv =====
// Nearest-K point tracker: keeps the MAX_ROWS points nearest the probe pixel,
// sorted nearest first by squared pixel distance, each with a 44-bit payload.
// Input items arrive on s_axis (command plus fields, packed in tdata); every
// item yields exactly one result item on m_axis. Configuration (enable, probe
// position, radius) is written through the i_cfg_* port; the user must do so
// only while the block idles, and the block itself does not enforce it. States
// from acceptance until the result is loaded (the next input item can be
// accepted at the first edge at which that result can be taken, receiver ready):
//   clear / open view / offer while disarmed or disabled : straight to the response
//   read row          : a registered read of the row memory, then the response
//   offer point       : sum, a tail check of a full list (a dropped point then
//                       goes to the response), a compare of each row that moves
//                       down and of the row that stops it, a write, the response
// Items are worked one at a time; the row memory has one read and one write
// port, and insertion walks the list one row per cycle from the tail, so the
// rate is set by that walk. A finished result sits in the output register, and
// the next item is accepted and worked while it waits; a new result waits in
// its last state until the output register frees up, and no input is taken
// meanwhile. Synchronous reset clears the list count, counter, armed flag and
// output valid and restores the configuration defaults; row contents are not
// cleared, since a row is only readable after it has been written.
module nearest_k_point_tracker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // cfg: index 0 enable, 1 probe_x, 2 probe_y, 3 radius
    input  logic                        i_cfg_wr_en,
    input  logic [1:0]                  i_cfg_index,
    input  logic [15:0]                 i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata from bit 0: cmd(2), pos_x(16), pos_y(16), view_width(16),
    // view_height(16), owner_player(4), shroud_status(4), ghost_owner(4),
    // tag(32), row_index(4), zero pad(6)
    input  logic [nkpt_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tdata from bit 0: armed(1), inserted(1), slot(4), in_radius(1),
    // row_count(5), considered(32), read_valid(1), read_dist_sq(33),
    // read_owner(4), read_shroud(4), read_ghost(4), read_tag(32), zero pad(6)
    output logic [nkpt_pkg::OUT_W-1:0]  m_axis_tdata
);

    localparam int AW = nkpt_pkg::AW;
    localparam int CW = nkpt_pkg::CW;

    // input fields
    logic [1:0]         in_cmd;
    logic signed [15:0] in_pos_x;
    logic signed [15:0] in_pos_y;
    logic [15:0]        in_view_w;
    logic [15:0]        in_view_h;
    logic [nkpt_pkg::PAY_W-1:0] in_payload;
    logic [3:0]         in_row_index;

    assign in_cmd       = s_axis_tdata[1:0];
    assign in_pos_x     = s_axis_tdata[17:2];
    assign in_pos_y     = s_axis_tdata[33:18];
    assign in_view_w    = s_axis_tdata[49:34];
    assign in_view_h    = s_axis_tdata[65:50];
    // payload: ghost, shroud, owner, tag from high to low
    assign in_payload   = {s_axis_tdata[77:74], s_axis_tdata[73:70],
                           s_axis_tdata[69:66], s_axis_tdata[109:78]};
    assign in_row_index = s_axis_tdata[113:110];

    // configuration registers
    logic               r_enable;
    logic signed [15:0] r_probe_x;
    logic signed [15:0] r_probe_y;
    logic [15:0]        r_radius;

    // tracker state
    nkpt_pkg::t_state   r_state, n_state;
    logic [CW-1:0]      r_rows_held;
    logic [31:0]        r_considered;
    logic               r_armed;

    // per-item working registers
    logic [nkpt_pkg::PAY_W-1:0]  r_payload;
    logic [31:0]                 r_sqx, r_sqy, r_r2;
    logic [nkpt_pkg::DIST_W-1:0] r_dist;
    logic [AW-1:0]               r_slot, n_slot;
    logic                        r_rd_valid;

    // pending result fields
    logic               r_res_inserted;
    logic [AW-1:0]      r_res_slot;
    logic               r_res_in_radius;
    logic               r_res_rvalid;
    nkpt_pkg::t_row     r_res_row;

    // output register
    logic                        r_m_valid;
    logic [nkpt_pkg::OUT_W-1:0]  r_m_data;

    // row memory
    nkpt_pkg::t_row     mem [nkpt_pkg::MAX_ROWS];
    nkpt_pkg::t_row     r_q;
    logic               mem_re, mem_we;
    logic [AW-1:0]      mem_raddr, mem_waddr;
    nkpt_pkg::t_row     mem_wdata;

    logic s_accept;
    logic resp_load;
    assign s_axis_tready = (r_state == nkpt_pkg::ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign resp_load     = (r_state == nkpt_pkg::ST_RESP) && (!r_m_valid || m_axis_tready);

    // distance arithmetic: 17-bit differences, squares fit in 32 bits
    logic signed [16:0] dx, dy;
    logic signed [33:0] prod_x, prod_y;
    logic [31:0]        prod_r;
    logic [nkpt_pkg::DIST_W-1:0] sum_d;
    logic               sum_in_radius;

    assign dx     = 17'(in_pos_x) - 17'(r_probe_x);
    assign dy     = 17'(in_pos_y) - 17'(r_probe_y);
    assign prod_x = dx * dx;
    assign prod_y = dy * dy;
    assign prod_r = r_radius * r_radius;
    assign sum_d  = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign sum_in_radius = (sum_d <= {1'b0, r_r2});

    // view test: probe inside [pos, pos + size) on both axes
    logic signed [17:0] qx18, qy18, px18, py18, xend, yend;
    logic               in_view;
    assign qx18 = 18'(r_probe_x);
    assign qy18 = 18'(r_probe_y);
    assign px18 = 18'(in_pos_x);
    assign py18 = 18'(in_pos_y);
    assign xend = px18 + $signed({2'b00, in_view_w});
    assign yend = py18 + $signed({2'b00, in_view_h});
    assign in_view = (qx18 >= px18) && (qx18 < xend) && (qy18 >= py18) && (qy18 < yend);

    logic list_full;
    logic read_ok;
    assign list_full = (32'(r_rows_held) >= 32'(nkpt_pkg::MAX_ROWS));
    assign read_ok   = (32'(in_row_index) < 32'(r_rows_held))
                    && (32'(in_row_index) < 32'(nkpt_pkg::MAX_ROWS));

    // next state and memory control
    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        mem_re    = 1'b0;
        mem_raddr = r_slot - AW'(1);
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = '{dist_sq: r_dist, payload: r_payload};
        case (r_state)
            nkpt_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (in_cmd)
                        nkpt_pkg::CMD_OFFER: begin
                            n_state = (r_enable && r_armed) ? nkpt_pkg::ST_SUM
                                                            : nkpt_pkg::ST_RESP;
                        end
                        nkpt_pkg::CMD_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = AW'(in_row_index);
                            n_state   = nkpt_pkg::ST_RDATA;
                        end
                        default: n_state = nkpt_pkg::ST_RESP;
                    endcase
                end
            end
            nkpt_pkg::ST_SUM: begin
                // full list: check the tail row first; else start at the tail
                if (list_full) begin
                    n_slot    = AW'(nkpt_pkg::MAX_ROWS - 1);
                    mem_re    = 1'b1;
                    mem_raddr = AW'(nkpt_pkg::MAX_ROWS - 1);
                    n_state   = nkpt_pkg::ST_FULL;
                end else begin
                    n_slot = AW'(r_rows_held);
                    if (r_rows_held == '0) begin
                        n_state = nkpt_pkg::ST_WRITE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(r_rows_held) - AW'(1);
                        n_state   = nkpt_pkg::ST_CMP;
                    end
                end
            end
            nkpt_pkg::ST_FULL: begin
                if (r_dist >= r_q.dist_sq) begin
                    n_state = nkpt_pkg::ST_RESP;
                end else if (r_slot != '0) begin
                    mem_re  = 1'b1;
                    n_state = nkpt_pkg::ST_CMP;
                end else begin
                    n_state = nkpt_pkg::ST_WRITE;
                end
            end
            nkpt_pkg::ST_CMP: begin
                // move the farther row down one place and look at the next
                if (r_q.dist_sq > r_dist) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_q;
                    n_slot    = r_slot - AW'(1);
                    if (n_slot != '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = n_slot - AW'(1);
                    end else begin
                        n_state = nkpt_pkg::ST_WRITE;
                    end
                end else begin
                    n_state = nkpt_pkg::ST_WRITE;
                end
            end
            nkpt_pkg::ST_WRITE: begin
                mem_we  = 1'b1;
                n_state = nkpt_pkg::ST_RESP;
            end
            nkpt_pkg::ST_RDATA: begin
                n_state = nkpt_pkg::ST_RESP;
            end
            nkpt_pkg::ST_RESP: begin
                if (resp_load) begin
                    n_state = nkpt_pkg::ST_IDLE;
                end
            end
            default: n_state = nkpt_pkg::ST_IDLE;
        endcase
    end

    // row memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_q <= mem[mem_raddr];
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nkpt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b1;
            r_probe_x <= -16'sd1;
            r_probe_y <= -16'sd1;
            r_radius  <= 16'd70;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                nkpt_pkg::REG_ENABLE:  r_enable  <= i_cfg_data[0];
                nkpt_pkg::REG_PROBE_X: r_probe_x <= i_cfg_data;
                nkpt_pkg::REG_PROBE_Y: r_probe_y <= i_cfg_data;
                nkpt_pkg::REG_RADIUS:  r_radius  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // tracker control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_held  <= '0;
            r_considered <= '0;
            r_armed      <= 1'b0;
        end else if (s_accept && r_enable && (in_cmd == nkpt_pkg::CMD_CLEAR)) begin
            r_rows_held  <= '0;
            r_considered <= '0;
            r_armed      <= 1'b0;
        end else if (s_accept && r_enable && (in_cmd == nkpt_pkg::CMD_VIEW)) begin
            r_armed <= in_view;
        end else if (r_state == nkpt_pkg::ST_SUM) begin
            if (r_considered != '1) begin
                r_considered <= r_considered + 32'd1;
            end
            if (!list_full) begin
                r_rows_held <= r_rows_held + CW'(1);
            end
        end
    end

    // working and pending-result registers
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (s_accept) begin
            r_payload       <= in_payload;
            r_sqx           <= prod_x[31:0];
            r_sqy           <= prod_y[31:0];
            r_r2            <= prod_r;
            r_rd_valid      <= read_ok;
            r_res_inserted  <= 1'b0;
            r_res_slot      <= '0;
            r_res_in_radius <= 1'b0;
            r_res_rvalid    <= 1'b0;
            r_res_row       <= '0;
        end
        case (r_state)
            nkpt_pkg::ST_SUM: begin
                r_dist          <= sum_d;
                r_res_in_radius <= sum_in_radius;
            end
            nkpt_pkg::ST_WRITE: begin
                r_res_inserted <= 1'b1;
                r_res_slot     <= r_slot;
            end
            nkpt_pkg::ST_RDATA: begin
                if (r_rd_valid) begin
                    r_res_rvalid <= 1'b1;
                    r_res_row    <= r_q;
                end
            end
            default: ;
        endcase
    end

    // output register: hold until taken, load the next result when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (resp_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (resp_load) begin
            r_m_data <= {6'd0,
                         r_res_row.payload[31:0],
                         r_res_row.payload[43:40],
                         r_res_row.payload[39:36],
                         r_res_row.payload[35:32],
                         r_res_row.dist_sq,
                         r_res_rvalid,
                         r_considered,
                         5'(r_rows_held),
                         r_res_in_radius,
                         4'(r_res_slot),
                         r_res_inserted,
                         r_armed};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // list count never passes the depth
    a_rows_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_rows_held) <= 32'(nkpt_pkg::MAX_ROWS))
        else $error("row count above list depth");

    // the memory is written only during an insertion walk
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == nkpt_pkg::ST_CMP || r_state == nkpt_pkg::ST_WRITE))
        else $error("row memory written outside insertion");

    // an enabled clear empties the list and disarms
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_enable && in_cmd == nkpt_pkg::CMD_CLEAR)
        |=> (r_rows_held == '0 && !r_armed && r_considered == '0))
        else $error("clear did not reset the list");

endmodule
